/* hw/rtl/sta_pkg.sv */
// Package for the sample timestamp accumulator.
// Holds widths, command codes, controller states and the control/status structs.
// No dependencies.
package sta_pkg;

    localparam int TS_W      = 64;
    localparam int NUM_W     = 32;
    localparam int DEN_W     = 16;
    localparam int SAMP_W    = 16;
    localparam int TICK_W    = 30;
    localparam int KIND_W    = 3;
    localparam int DIV_W     = 64;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int PROD_A_W  = SAMP_W + TICK_W;

    localparam logic [TICK_W-1:0] TICK_RATE_RST = TICK_W'(1000000);

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_INIT    = 3'd0;
    localparam t_kind KIND_CHANGE  = 3'd1;
    localparam t_kind KIND_SET     = 3'd2;
    localparam t_kind KIND_ADVANCE = 3'd3;
    localparam t_kind KIND_REWIND  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIV_LOAD,
        ST_DIV,
        ST_UPDATE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic latch;
        logic mul_a;
        logic mul_b;
        logic div_start;
        logic update;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  stamp_valid;
        logic  div_done;
        logic  out_free;
    } t_dp_sts;

endpackage

/* hw/rtl/sta_if.sv */
// Channel interfaces for the sample timestamp accumulator: command, result, config.
// Depends on sta_pkg for field widths.
interface sta_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [sta_pkg::KIND_W-1:0]    kind;
    logic [sta_pkg::SAMP_W-1:0]    sample_count;
    logic [sta_pkg::NUM_W-1:0]     rate_num_in;
    logic [sta_pkg::DEN_W-1:0]     rate_den_in;
    logic signed [sta_pkg::TS_W-1:0] new_timestamp;

    modport source (output valid, kind, sample_count, rate_num_in, rate_den_in,
                    new_timestamp, input ready);
    modport sink (input valid, kind, sample_count, rate_num_in, rate_den_in,
                  new_timestamp, output ready);
endinterface

interface sta_res_if;
    logic                            valid;
    logic                            ready;
    logic signed [sta_pkg::TS_W-1:0] timestamp;
    logic                            timestamp_valid;

    modport source (output valid, timestamp, timestamp_valid, input ready);
    modport sink (input valid, timestamp, timestamp_valid, output ready);
endinterface

interface sta_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [sta_pkg::TICK_W-1:0]   tick_rate;

    modport source (output valid, tick_rate, input ready);
    modport sink (input valid, tick_rate, output ready);
endinterface

/* hw/rtl/sta_ctrl.sv */
// Controller state machine for the sample timestamp accumulator.
// Sequences latch, multiply, divide, update and result load. Depends on sta_pkg.
module sta_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sta_pkg::t_dp_sts i_sts,
    output sta_pkg::t_dp_cmd o_cmd
);

    sta_pkg::t_state r_state;
    sta_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sta_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sta_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sta_pkg::ST_DECODE;
            end
            sta_pkg::ST_DECODE: begin
                priority if (i_sts.kind == sta_pkg::KIND_CHANGE) begin
                    n_state = sta_pkg::ST_MUL_A;
                end else if ((i_sts.kind == sta_pkg::KIND_ADVANCE ||
                              i_sts.kind == sta_pkg::KIND_REWIND) && i_sts.stamp_valid) begin
                    n_state = sta_pkg::ST_MUL_A;
                end else begin
                    n_state = sta_pkg::ST_UPDATE;
                end
            end
            sta_pkg::ST_MUL_A: begin
                if (i_sts.kind == sta_pkg::KIND_CHANGE) n_state = sta_pkg::ST_DIV_LOAD;
                else n_state = sta_pkg::ST_MUL_B;
            end
            sta_pkg::ST_MUL_B:    n_state = sta_pkg::ST_DIV_LOAD;
            sta_pkg::ST_DIV_LOAD: n_state = sta_pkg::ST_DIV;
            sta_pkg::ST_DIV: begin
                if (i_sts.div_done) n_state = sta_pkg::ST_UPDATE;
            end
            sta_pkg::ST_UPDATE:   n_state = sta_pkg::ST_OUT;
            sta_pkg::ST_OUT: begin
                if (i_sts.out_free) n_state = sta_pkg::ST_IDLE;
            end
            default:              n_state = sta_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sta_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            sta_pkg::ST_MUL_A:    o_cmd.mul_a     = 1'b1;
            sta_pkg::ST_MUL_B:    o_cmd.mul_b     = 1'b1;
            sta_pkg::ST_DIV_LOAD: o_cmd.div_start = 1'b1;
            sta_pkg::ST_UPDATE:   o_cmd.update    = 1'b1;
            sta_pkg::ST_OUT:      o_cmd.out_load  = i_sts.out_free;
            default: begin
            end
        endcase
    end

endmodule

/* hw/rtl/sta_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit dividend, 32-bit divisor.
// Depends on sta_pkg for widths.
module sta_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sta_pkg::DIV_W-1:0]   i_dvd,
    input  logic [sta_pkg::NUM_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [sta_pkg::DIV_W-1:0]   o_quotient,
    output logic [sta_pkg::NUM_W-1:0]   o_remainder
);

    logic [sta_pkg::DIV_W-1:0]     r_quo;
    logic [sta_pkg::NUM_W-1:0]     r_rem;
    logic [sta_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [sta_pkg::NUM_W:0] trial;
    logic [sta_pkg::NUM_W:0] diff;
    logic                    ge;

    assign trial = {r_rem, r_quo[sta_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, i_divisor};
    assign ge    = trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == sta_pkg::DIV_CNT_W'(sta_pkg::DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dvd;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[sta_pkg::DIV_W-2:0], ge};
            r_rem <= ge ? diff[sta_pkg::NUM_W-1:0] : trial[sta_pkg::NUM_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    a_done_excl_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("divider busy and done together");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> (r_rem < i_divisor))
        else $error("divider remainder not below divisor");

endmodule

/* hw/rtl/sta_dp.sv */
// Datapath for the sample timestamp accumulator: state, command latch, multipliers,
// divider and result register. Depends on sta_pkg, sta_if and sta_div.
module sta_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sta_pkg::t_dp_cmd i_cmd,
    output sta_pkg::t_dp_sts o_sts,
    sta_cmd_if.sink          i_in,
    sta_cfg_if.sink          i_cfg,
    sta_res_if.source        o_res
);

    logic [sta_pkg::TICK_W-1:0]      r_tick;
    logic signed [sta_pkg::TS_W-1:0] r_stamp;
    logic                            r_stamp_valid;
    logic [sta_pkg::NUM_W-1:0]       r_frac;
    logic [sta_pkg::NUM_W-1:0]       r_num;
    logic [sta_pkg::DEN_W-1:0]       r_den;

    sta_pkg::t_kind                  r_kind;
    logic [sta_pkg::SAMP_W-1:0]      r_samples;
    logic [sta_pkg::NUM_W-1:0]       r_num_in;
    logic [sta_pkg::DEN_W-1:0]       r_den_in;
    logic signed [sta_pkg::TS_W-1:0] r_new_ts;
    logic [sta_pkg::DIV_W-1:0]       r_prod;

    logic                            r_out_full;
    logic signed [sta_pkg::TS_W-1:0] r_out_ts;
    logic                            r_out_valid;

    logic                            div_done;
    logic [sta_pkg::DIV_W-1:0]       quo;
    logic [sta_pkg::NUM_W-1:0]       rem;
    logic [sta_pkg::NUM_W-1:0]       num_eff;
    logic [sta_pkg::NUM_W:0]         adv_sum;
    logic                            carry;
    logic                            borrow;
    logic [sta_pkg::NUM_W:0]         rew_frac;

    sta_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dvd       (r_prod),
        .i_divisor   (r_num),
        .o_done      (div_done),
        .o_quotient  (quo),
        .o_remainder (rem)
    );

    assign num_eff  = (r_num_in == '0) ? sta_pkg::NUM_W'(1) : r_num_in;
    assign adv_sum  = {1'b0, r_frac} + {1'b0, rem};
    assign carry    = adv_sum >= {1'b0, r_num};
    assign borrow   = r_frac < rem;
    assign rew_frac = {1'b0, r_frac} + (borrow ? {1'b0, r_num} : '0) - {1'b0, rem};

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= sta_pkg::TICK_RATE_RST;
        end else if (i_cfg.valid) begin
            r_tick <= i_cfg.tick_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind    <= i_in.kind;
            r_samples <= i_in.sample_count;
            r_num_in  <= i_in.rate_num_in;
            r_den_in  <= i_in.rate_den_in;
            r_new_ts  <= i_in.new_timestamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_a) begin
            if (r_kind == sta_pkg::KIND_CHANGE) begin
                r_prod <= sta_pkg::DIV_W'(r_frac) * sta_pkg::DIV_W'(num_eff);
            end else begin
                r_prod <= sta_pkg::DIV_W'(sta_pkg::PROD_A_W'(r_samples) *
                                         sta_pkg::PROD_A_W'(r_tick));
            end
        end else if (i_cmd.mul_b) begin
            r_prod <= sta_pkg::DIV_W'(r_prod[sta_pkg::PROD_A_W-1:0]) *
                      sta_pkg::DIV_W'(r_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp       <= '0;
            r_stamp_valid <= 1'b0;
            r_frac        <= '0;
            r_num         <= sta_pkg::NUM_W'(1);
            r_den         <= sta_pkg::DEN_W'(1);
        end else if (i_cmd.update) begin
            unique case (r_kind)
                sta_pkg::KIND_INIT: begin
                    r_num         <= num_eff;
                    r_den         <= r_den_in;
                    r_stamp       <= '0;
                    r_stamp_valid <= 1'b0;
                    r_frac        <= '0;
                end
                sta_pkg::KIND_CHANGE: begin
                    r_frac <= quo[sta_pkg::NUM_W-1:0];
                    r_num  <= num_eff;
                    r_den  <= r_den_in;
                end
                sta_pkg::KIND_SET: begin
                    r_stamp       <= r_new_ts;
                    r_stamp_valid <= 1'b1;
                    r_frac        <= '0;
                end
                sta_pkg::KIND_ADVANCE: begin
                    if (r_stamp_valid) begin
                        r_stamp <= r_stamp + $signed(quo) + sta_pkg::TS_W'(carry);
                        r_frac  <= carry ? adv_sum[sta_pkg::NUM_W-1:0] - r_num
                                         : adv_sum[sta_pkg::NUM_W-1:0];
                    end
                end
                sta_pkg::KIND_REWIND: begin
                    if (r_stamp_valid) begin
                        r_stamp <= r_stamp - $signed(quo) - sta_pkg::TS_W'(borrow);
                        r_frac  <= rew_frac[sta_pkg::NUM_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_full <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_full <= 1'b1;
        end else if (o_res.ready) begin
            r_out_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ts    <= r_stamp_valid ? r_stamp : '0;
            r_out_valid <= r_stamp_valid;
        end
    end

    assign o_res.valid           = r_out_full;
    assign o_res.timestamp       = r_out_ts;
    assign o_res.timestamp_valid = r_out_valid;

    assign o_sts.kind        = r_kind;
    assign o_sts.stamp_valid = r_stamp_valid;
    assign o_sts.div_done    = div_done;
    assign o_sts.out_free    = !r_out_full || o_res.ready;

    a_frac_below_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac < r_num)
        else $error("remainder not below numerator");

    a_num_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_num != '0)
        else $error("numerator is zero");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_full || o_res.ready))
        else $error("result register overwritten before taken");

endmodule

/* hw/rtl/sample_timestamp_accumulator_top.sv */
// Top level of the sample timestamp accumulator: controller plus datapath.
// Depends on sta_pkg, sta_if, sta_ctrl, sta_dp.
//
//   port    dir  payload                                              beat when
//   i_cmd   in   kind, sample_count, rate_num_in, rate_den_in,        valid && ready
//                new_timestamp
//   o_res   out  timestamp, timestamp_valid                           valid && ready
//   i_cfg   in   tick_rate                                            valid && ready
//
// Advance and rewind on a valid timestamp pass through the multiply states MUL_A and MUL_B and
// the 64-step radix-2 divider; change rate uses only MUL_A and the divider. Init, set timestamp,
// unused kinds and advance/rewind on an invalid timestamp go straight from decode to update.
// Synchronous active-low reset; no clearing pass, ready as soon as reset is released.
// A result waits in the output register; the next command is accepted once it is loaded.
module sample_timestamp_accumulator_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sta_cmd_if.sink   i_cmd,
    sta_cfg_if.sink   i_cfg,
    sta_res_if.source o_res
);

    sta_pkg::t_dp_cmd dp_cmd;
    sta_pkg::t_dp_sts dp_sts;
    logic             in_ready;

    assign i_cmd.ready = in_ready && i_rst_n;

    sta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    sta_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .i_in    (i_cmd),
        .i_cfg   (i_cfg),
        .o_res   (o_res)
    );

endmodule
